// ----- rtl/core/sensor_reply_frame_checker_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Sensor reply frame checker - assertion macros
// Concurrent checks that refer to clk and arst_n of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SENSOR_REPLY_FRAME_CHECKER_UNIT_MACROS_SVH
`define SENSOR_REPLY_FRAME_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SRFC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srfc check failed");
// next-cycle implication
`define SRFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srfc check failed");
`else
`define SRFC_ASSERT_NOW(label, ante, cons)
`define SRFC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/srfc_pkg.sv -----
// ----------------------------------------------------------------------------
// srfc_pkg
// Types, constants and the crc-8 byte update of the sensor reply frame checker.
// ----------------------------------------------------------------------------
package srfc_pkg;

	localparam logic [7:0]  CRC_POLY   = 8'h31;
	localparam logic [7:0]  CRC_INIT   = 8'hFF;
	localparam logic [31:0] FAIL_VALUE = 32'hFFFF_FFFF;
	localparam logic [31:0] TVOC_MASK  = 32'h00FF_FFFF;
	localparam logic [31:0] RES_SCALE  = 32'd100;
	localparam logic [2:0]  DATA_BYTES = 3'd4;

	localparam logic [1:0] KIND_VERSION = 2'd0;
	localparam logic [1:0] KIND_GAS     = 2'd1;
	localparam logic [1:0] KIND_TVOC    = 2'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CRC_BAD  = 2'd1,
		ST_BUS_FAIL = 2'd2
	} status_t;

	typedef struct packed {
		logic       bus_failed;
		logic [1:0] read_kind;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] reading;
	} result_t;

	// core to output register
	typedef struct packed {
		logic    load;
		result_t result;
	} core_out_t;

	// msb-first crc-8, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/srfc_in_stage.sv -----
// ----------------------------------------------------------------------------
// srfc_in_stage
// Input register: holds one accepted byte until the frame core takes it.
// ----------------------------------------------------------------------------
module srfc_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  srfc_pkg::item_t in_item,
	input  logic            take,
	output logic            valid_s1,
	output srfc_pkg::item_t item_s1
);

	logic load;

	assign in_ready = !valid_s1 || take;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- rtl/core/srfc_frame_core.sv -----
// ----------------------------------------------------------------------------
// srfc_frame_core
// Frame state, crc update, checksum compare and reading post-processing.
// ----------------------------------------------------------------------------
`include "sensor_reply_frame_checker_unit_macros.svh"

module srfc_frame_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  srfc_pkg::item_t     item_s1,
	input  logic                out_free,
	output logic                take,
	output srfc_pkg::core_out_t core_out
);

	logic [2:0]  byte_pos_q;
	logic [7:0]  crc_q;
	logic [31:0] shift_q;
	logic        is_data;
	logic        has_result;
	logic [31:0] value;

	assign is_data    = !item_s1.bus_failed && (byte_pos_q < srfc_pkg::DATA_BYTES);
	assign has_result = !is_data;
	assign take       = valid_s1 && (is_data || out_free);

	always_comb begin
		case (item_s1.read_kind)
			srfc_pkg::KIND_GAS:  value = 32'(shift_q * srfc_pkg::RES_SCALE);
			srfc_pkg::KIND_TVOC: value = shift_q & srfc_pkg::TVOC_MASK;
			default:             value = shift_q;
		endcase

		core_out.load = take && has_result;
		if (item_s1.bus_failed) begin
			core_out.result.status  = srfc_pkg::ST_BUS_FAIL;
			core_out.result.reading = srfc_pkg::FAIL_VALUE;
		end else if (crc_q != item_s1.rx_byte) begin
			core_out.result.status  = srfc_pkg::ST_CRC_BAD;
			core_out.result.reading = srfc_pkg::FAIL_VALUE;
		end else begin
			core_out.result.status  = srfc_pkg::ST_OK;
			core_out.result.reading = value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= 3'd0;
			crc_q      <= srfc_pkg::CRC_INIT;
			shift_q    <= 32'd0;
		end else if (take) begin
			if (is_data) begin
				byte_pos_q <= byte_pos_q + 3'd1;
				crc_q      <= srfc_pkg::crc8_byte(crc_q, item_s1.rx_byte);
				shift_q    <= {shift_q[23:0], item_s1.rx_byte};
			end else begin
				// any result ends the frame
				byte_pos_q <= 3'd0;
				crc_q      <= srfc_pkg::CRC_INIT;
				shift_q    <= 32'd0;
			end
		end
	end

	`SRFC_ASSERT_NOW(a_pos_range, 1'b1, byte_pos_q <= srfc_pkg::DATA_BYTES)
	`SRFC_ASSERT_NEXT(a_restart, take && has_result, byte_pos_q == 3'd0 && crc_q == srfc_pkg::CRC_INIT)
	`SRFC_ASSERT_NEXT(a_data_advance, take && is_data, byte_pos_q != 3'd0 && byte_pos_q == $past(byte_pos_q) + 3'd1)
	`SRFC_ASSERT_NOW(a_fail_sentinel, core_out.load && core_out.result.status != srfc_pkg::ST_OK, core_out.result.reading == srfc_pkg::FAIL_VALUE)

endmodule

// ----- rtl/core/srfc_out_stage.sv -----
// ----------------------------------------------------------------------------
// srfc_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module srfc_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  srfc_pkg::core_out_t core_out,
	output logic                out_free,
	output logic                out_valid,
	input  logic                out_ready,
	output srfc_pkg::result_t   out_result
);

	logic              valid_q;
	srfc_pkg::result_t result_q;

	assign out_free   = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (core_out.load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_out.load) begin
			result_q <= core_out.result;
		end
	end

endmodule

// ----- rtl/core/sensor_reply_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// sensor_reply_frame_checker_unit
// Checks 5-byte sensor replies (four data bytes msb first, then crc-8) and
// emits one processed reading or failure status per frame.
//
//   channel   dir   tdata                 tuser
//   s_axis    in    [7:0] rx_byte         [1:0] read_kind, [2] bus_failed
//   m_axis    out   [31:0] reading        [1:0] status
//
// one byte is accepted per cycle unless the input register is stalled; a byte
// waits in the input register until the frame core takes it, and its result
// then goes to the result register, so each result passes both registers.
// the frame core updates the crc and the shift value once per data byte.
// reset clears the frame state to position zero, crc 0xff, empty value.
// a held result stalls input only once a checksum or bus-failure byte waits in
// the input register; data bytes keep moving.
// ----------------------------------------------------------------------------
`include "sensor_reply_frame_checker_unit_macros.svh"

module sensor_reply_frame_checker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [2:0]  s_axis_tuser,   // [1:0] read_kind, [2] bus_failed
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] reading
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	srfc_pkg::item_t     in_item;
	srfc_pkg::item_t     item_s1;
	srfc_pkg::core_out_t core_out;
	srfc_pkg::result_t   out_result;
	logic                valid_s1;
	logic                take;
	logic                out_free;

	assign in_item.rx_byte    = s_axis_tdata;
	assign in_item.read_kind  = s_axis_tuser[1:0];
	assign in_item.bus_failed = s_axis_tuser[2];

	srfc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	srfc_frame_core u_frame_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.take     (take),
		.core_out (core_out)
	);

	srfc_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.core_out   (core_out),
		.out_free   (out_free),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (out_result)
	);

	assign m_axis_tdata = out_result.reading;
	assign m_axis_tuser = out_result.status;

	// a waiting result is never overwritten
	`SRFC_ASSERT_NOW(a_no_overwrite, m_axis_tvalid && !m_axis_tready, !core_out.load)
	// an occupied input register that cannot move blocks new transfers
	`SRFC_ASSERT_NOW(a_in_block, valid_s1 && !take, !s_axis_tready)

endmodule

// ----- dv/tb_sensor_reply_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// tb_sensor_reply_frame_checker_unit
// Drives 5-byte sensor replies (four data bytes, then a crc-8 byte) into the
// frame checker. A short table covers the extremes, every read kind, a bus
// failure and a checksum mismatch; random frames follow, most of them with a
// correct checksum and some broken by a wrong checksum or a bus failure.
// Each result is checked against the in-bench model or a pinned typed result.
// ----------------------------------------------------------------------------
module tb_sensor_reply_frame_checker_unit;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1150;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_START   = 400;
	localparam int HOLD_LEN     = 400;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [1:0] {
		CK_GIVEN,
		CK_RIGHT,
		CK_WRONG
	} checksum_mode_t;

	// one directed transfer; the typed-in result is used only when pinned
	typedef struct packed {
		logic [7:0]        rx_byte;
		logic [1:0]        read_kind;
		logic              bus_failed;
		checksum_mode_t    mode;
		logic              pinned;
		srfc_pkg::status_t status;
		logic [31:0]       reading;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
	logic [2:0]  s_axis_tuser;   // [1:0] read_kind, [2] bus_failed
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] reading
	logic [1:0]  m_axis_tuser;   // [1:0] status

	sensor_reply_frame_checker_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// frame state of the in-bench model
	logic [2:0]  frame_pos;
	logic [7:0]  frame_crc;
	logic [31:0] frame_value;

	srfc_pkg::result_t pending_replies[$];
	srfc_pkg::result_t oldest_reply;
	int                mismatches;
	int                cycles;
	int                ready_cycle;
	int                burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bit-serial crc-8, poly 0x31, msb first
	function automatic logic [7:0] crc_after(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[7] ^ b[k];
			c = {c[6:0], 1'b0} ^ (fb ? srfc_pkg::CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	task automatic clear_frame();
		frame_pos   = '0;
		frame_crc   = srfc_pkg::CRC_INIT;
		frame_value = '0;
	endtask

	task automatic predict_reply(input srfc_pkg::item_t it, output bit got,
			output srfc_pkg::result_t r);
		logic [31:0] v;
		got       = 1'b0;
		r.status  = srfc_pkg::ST_OK;
		r.reading = '0;
		if (it.bus_failed) begin
			clear_frame();
			got       = 1'b1;
			r.status  = srfc_pkg::ST_BUS_FAIL;
			r.reading = srfc_pkg::FAIL_VALUE;
		end else if (frame_pos < srfc_pkg::DATA_BYTES) begin
			frame_crc   = crc_after(frame_crc, it.rx_byte);
			frame_value = {frame_value[23:0], it.rx_byte};
			frame_pos   = frame_pos + 3'd1;
		end else if (it.rx_byte != frame_crc) begin
			clear_frame();
			got       = 1'b1;
			r.status  = srfc_pkg::ST_CRC_BAD;
			r.reading = srfc_pkg::FAIL_VALUE;
		end else begin
			case (it.read_kind)
				srfc_pkg::KIND_GAS: begin
					v = frame_value * srfc_pkg::RES_SCALE;
				end
				srfc_pkg::KIND_TVOC: begin
					v = frame_value & srfc_pkg::TVOC_MASK;
				end
				default: begin
					v = frame_value;
				end
			endcase
			clear_frame();
			got       = 1'b1;
			r.status  = srfc_pkg::ST_OK;
			r.reading = v;
		end
	endtask

	// offer one byte, wait for the transfer, then maybe leave a gap
	task automatic send_byte(input srfc_pkg::item_t it, input bit pinned,
			input srfc_pkg::result_t typed);
		bit                got;
		srfc_pkg::result_t r;
		int                gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= it.rx_byte;
		s_axis_tuser  <= {it.bus_failed, it.read_kind};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_reply(it, got, r);
		if (got) begin
			pending_replies.push_back(pinned ? typed : r);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// receiver: steps through four stall patterns in turn, with one long hold-off
	initial begin
		m_axis_tready = 1'b0;
		ready_cycle   = 0;
		forever begin
			@(negedge clk);
			ready_cycle++;
			if (ready_cycle >= HOLD_START && ready_cycle < HOLD_START + HOLD_LEN) begin
				m_axis_tready <= 1'b0;
			end else begin
				case ((ready_cycle / 64) % 4)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 1);
					2: m_axis_tready <= ((ready_cycle % 3) == 0);
					default: m_axis_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %0d reading %h",
					$time, m_axis_tuser, m_axis_tdata);
				mismatches++;
			end else begin
				oldest_reply = pending_replies.pop_front();
				if (srfc_pkg::status_t'(m_axis_tuser) !== oldest_reply.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, oldest_reply.status, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata !== oldest_reply.reading) begin
					$display("%0t: reading mismatch: expected %h, actual %h",
						$time, oldest_reply.reading, m_axis_tdata);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, pending_replies.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		plan_row_t         plan[26];
		srfc_pkg::item_t   it;
		srfc_pkg::result_t typed;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		mismatches    = 0;
		cycles        = 0;
		burst_left    = 0;
		clear_frame();

		plan = '{
			// bus failure right after reset
			'{8'hFF, KIND_UNUSED, 1'b1, CK_GIVEN, 1'b1, srfc_pkg::ST_BUS_FAIL,
				srfc_pkg::FAIL_VALUE},
			// all-zero value, version
			'{8'h00, srfc_pkg::KIND_VERSION, 1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h00, srfc_pkg::KIND_GAS,     1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h00, srfc_pkg::KIND_TVOC,    1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h00, KIND_UNUSED,            1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h00, srfc_pkg::KIND_VERSION, 1'b0, CK_RIGHT, 1'b1, srfc_pkg::ST_OK, 32'h0},
			// all-ones value, gas resistance wraps
			'{8'hFF, KIND_UNUSED,            1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'hFF, srfc_pkg::KIND_TVOC,    1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'hFF, srfc_pkg::KIND_GAS,     1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'hFF, srfc_pkg::KIND_VERSION, 1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'hFF, srfc_pkg::KIND_GAS,     1'b0, CK_RIGHT, 1'b0, srfc_pkg::ST_OK, 32'h0},
			// tvoc drops the top byte
			'{8'h12, srfc_pkg::KIND_VERSION, 1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h34, srfc_pkg::KIND_VERSION, 1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h56, srfc_pkg::KIND_VERSION, 1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h78, srfc_pkg::KIND_VERSION, 1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h00, srfc_pkg::KIND_TVOC,    1'b0, CK_RIGHT, 1'b0, srfc_pkg::ST_OK, 32'h0},
			// unused kind passes the raw value
			'{8'hA5, srfc_pkg::KIND_GAS,     1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h5A, srfc_pkg::KIND_GAS,     1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h0F, srfc_pkg::KIND_GAS,     1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'hF0, srfc_pkg::KIND_GAS,     1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h00, KIND_UNUSED,            1'b0, CK_RIGHT, 1'b0, srfc_pkg::ST_OK, 32'h0},
			// checksum mismatch fails even for version
			'{8'h80, srfc_pkg::KIND_TVOC,    1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h01, srfc_pkg::KIND_TVOC,    1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h7F, srfc_pkg::KIND_TVOC,    1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'hFE, srfc_pkg::KIND_TVOC,    1'b0, CK_GIVEN, 1'b0, srfc_pkg::ST_OK, 32'h0},
			'{8'h00, srfc_pkg::KIND_VERSION, 1'b0, CK_WRONG, 1'b1, srfc_pkg::ST_CRC_BAD,
				srfc_pkg::FAIL_VALUE}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[n]) begin
			it.bus_failed = plan[n].bus_failed;
			it.read_kind  = plan[n].read_kind;
			case (plan[n].mode)
				CK_RIGHT: it.rx_byte = frame_crc;
				CK_WRONG: it.rx_byte = ~frame_crc;
				default:  it.rx_byte = plan[n].rx_byte;
			endcase
			typed.status  = plan[n].status;
			typed.reading = plan[n].reading;
			send_byte(it, plan[n].pinned, typed);
		end

		// mostly well-formed frames; wrong checksums and bus failures break some
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			it.bus_failed = ($urandom_range(0, 24) == 0);
			it.read_kind  = 2'($urandom_range(0, 3));
			if (frame_pos < srfc_pkg::DATA_BYTES) begin
				case ($urandom_range(0, 7))
					0: it.rx_byte = 8'h00;
					1: it.rx_byte = 8'hFF;
					default: it.rx_byte = 8'($urandom);
				endcase
			end else if ($urandom_range(0, 9) < 8) begin
				it.rx_byte = frame_crc;
			end else begin
				it.rx_byte = 8'($urandom);
			end
			typed = '0;
			send_byte(it, 1'b0, typed);
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
